>>> rtl/core/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg
// shared types, codes and defaults of the bounded task admission unit
// ----------------------------------------------------------------------------
package bta_pkg;

    localparam int RUN_SLOTS_DEF  = 16;
    localparam int PEND_DEPTH_DEF = 16;
    localparam int TAG_WIDTH_DEF  = 32;

    localparam int ID_W     = 32;
    localparam int LIMIT_W  = 5;
    localparam int STATUS_W = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_STARTED   = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_DROPPED   = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_rstat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PR_CHK,
        S_PR_EMIT,
        S_RS_RD,
        S_RS_CMP,
        S_PS_CHK,
        S_PS_RD,
        S_PS_CMP,
        S_DECIDE,
        S_ADD_START,
        S_STATUS
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic   accept;
        logic   idx_clr;
        logic   idx_inc;
        logic   run_rd;
        logic   run_cmp;
        logic   pend_rd_idx;
        logic   pend_rd_head;
        logic   pend_cmp;
        logic   pend_rm_done;
        logic   promote_take;
        logic   add_start;
        logic   add_queue;
        logic   emit_status;
        t_rstat code;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic req_type;
        logic room;
        logic pend_nonempty;
        logic pend_full;
        logic run_last;
        logic pend_scan_done;
        logic dup;
        logic found;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/core/bta_ctrl.sv
// ----------------------------------------------------------------------------
// bta_ctrl
// request sequencer: promote, scan, decide and emit
// ----------------------------------------------------------------------------
module bta_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_req_type,
    input  bta_pkg::t_sts i_sts,
    output logic          o_busy,
    output bta_pkg::t_cmd o_cmd
);

    bta_pkg::t_state r_state, n_state;
    bta_pkg::t_rstat r_code, n_code;
    logic            w_acc;

    assign o_busy = (r_state != bta_pkg::S_IDLE);
    assign w_acc  = i_in_valid && (r_state == bta_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bta_pkg::S_IDLE;
            r_code  <= bta_pkg::ST_STARTED;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        case (r_state)
            bta_pkg::S_IDLE: begin
                if (w_acc) begin
                    // add promotes first, remove scans first
                    n_state = (i_req_type == bta_pkg::REQ_ADD) ?
                              bta_pkg::S_PR_CHK : bta_pkg::S_RS_RD;
                end
            end
            bta_pkg::S_PR_CHK: begin
                if (i_sts.pend_nonempty && i_sts.room)
                    n_state = bta_pkg::S_PR_EMIT;
                else if (i_sts.req_type == bta_pkg::REQ_ADD)
                    n_state = bta_pkg::S_RS_RD;
                else
                    n_state = bta_pkg::S_STATUS;
            end
            bta_pkg::S_PR_EMIT: begin
                if (i_sts.out_free)
                    n_state = bta_pkg::S_PR_CHK;
            end
            bta_pkg::S_RS_RD: n_state = bta_pkg::S_RS_CMP;
            bta_pkg::S_RS_CMP: begin
                n_state = i_sts.run_last ? bta_pkg::S_PS_CHK : bta_pkg::S_RS_RD;
            end
            bta_pkg::S_PS_CHK: begin
                if (!i_sts.pend_scan_done)
                    n_state = bta_pkg::S_PS_RD;
                else if (i_sts.req_type == bta_pkg::REQ_ADD)
                    n_state = bta_pkg::S_DECIDE;
                else
                    n_state = bta_pkg::S_PR_CHK;
            end
            bta_pkg::S_PS_RD:  n_state = bta_pkg::S_PS_CMP;
            bta_pkg::S_PS_CMP: n_state = bta_pkg::S_PS_CHK;
            bta_pkg::S_DECIDE: begin
                if (i_sts.dup) begin
                    n_code  = bta_pkg::ST_DUPLICATE;
                    n_state = bta_pkg::S_STATUS;
                end else if (i_sts.room) begin
                    n_code  = bta_pkg::ST_STARTED;
                    n_state = bta_pkg::S_ADD_START;
                end else if (!i_sts.pend_full) begin
                    n_code  = bta_pkg::ST_QUEUED;
                    n_state = bta_pkg::S_STATUS;
                end else begin
                    n_code  = bta_pkg::ST_DROPPED;
                    n_state = bta_pkg::S_STATUS;
                end
            end
            bta_pkg::S_ADD_START: begin
                if (i_sts.out_free)
                    n_state = bta_pkg::S_STATUS;
            end
            bta_pkg::S_STATUS: begin
                if (i_sts.out_free)
                    n_state = bta_pkg::S_IDLE;
            end
            default: n_state = bta_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.code = r_code;
        case (r_state)
            bta_pkg::S_IDLE: o_cmd.accept = w_acc;
            bta_pkg::S_PR_CHK: begin
                if (i_sts.pend_nonempty && i_sts.room)
                    o_cmd.pend_rd_head = 1'b1;
                else if (i_sts.req_type == bta_pkg::REQ_ADD)
                    o_cmd.idx_clr = 1'b1;
            end
            bta_pkg::S_PR_EMIT: o_cmd.promote_take = i_sts.out_free;
            bta_pkg::S_RS_RD:   o_cmd.run_rd = 1'b1;
            bta_pkg::S_RS_CMP: begin
                o_cmd.run_cmp = 1'b1;
                if (i_sts.run_last)
                    o_cmd.idx_clr = 1'b1;
                else
                    o_cmd.idx_inc = 1'b1;
            end
            bta_pkg::S_PS_CHK: begin
                if (i_sts.pend_scan_done && i_sts.req_type == bta_pkg::REQ_REMOVE)
                    o_cmd.pend_rm_done = 1'b1;
            end
            bta_pkg::S_PS_RD: o_cmd.pend_rd_idx = 1'b1;
            bta_pkg::S_PS_CMP: begin
                o_cmd.pend_cmp = 1'b1;
                o_cmd.idx_inc  = 1'b1;
            end
            bta_pkg::S_DECIDE: begin
                o_cmd.add_queue = !i_sts.dup && !i_sts.room && !i_sts.pend_full;
            end
            bta_pkg::S_ADD_START: o_cmd.add_start = i_sts.out_free;
            bta_pkg::S_STATUS: begin
                o_cmd.emit_status = i_sts.out_free;
                if (i_sts.req_type == bta_pkg::REQ_REMOVE)
                    o_cmd.code = i_sts.found ? bta_pkg::ST_REMOVED : bta_pkg::ST_NOT_FOUND;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> rtl/core/bta_dp.sv
// ----------------------------------------------------------------------------
// bta_dp
// tag stores, slot valid bits, fifo pointers, limit register, output word
// ----------------------------------------------------------------------------
module bta_dp #(
    parameter int RUN_SLOTS  = bta_pkg::RUN_SLOTS_DEF,
    parameter int PEND_DEPTH = bta_pkg::PEND_DEPTH_DEF,
    parameter int TAG_WIDTH  = bta_pkg::TAG_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_type,
    input  logic [bta_pkg::ID_W-1:0]      i_task_id,
    input  logic                          i_cfg_valid,
    input  logic [bta_pkg::LIMIT_W-1:0]   i_cfg_data,
    input  logic                          i_out_stall,
    input  bta_pkg::t_cmd                 i_cmd,
    output bta_pkg::t_sts                 o_sts,
    output logic                          o_out_valid,
    output logic                          o_kind,
    output logic [bta_pkg::ID_W-1:0]      o_out_id,
    output logic [bta_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last
);

    localparam int RA = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
    localparam int RC = $clog2(RUN_SLOTS + 1);
    localparam int PA = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
    localparam int PC = $clog2(PEND_DEPTH + 1);
    localparam int IW = (RC > PC) ? RC : PC;
    localparam int LW = (RC > bta_pkg::LIMIT_W) ? RC : bta_pkg::LIMIT_W;

    logic [TAG_WIDTH-1:0]        run_mem  [RUN_SLOTS];
    logic [TAG_WIDTH-1:0]        pend_mem [PEND_DEPTH];

    logic                        r_req_type;
    logic [TAG_WIDTH-1:0]        r_tag;
    logic [bta_pkg::LIMIT_W-1:0] r_limit;
    logic [RUN_SLOTS-1:0]        r_run_vld;
    logic [RC-1:0]               r_run_cnt;
    logic [PA-1:0]               r_head;
    logic [PC-1:0]               r_count;
    logic [IW-1:0]               r_idx;
    logic [PC-1:0]               r_wptr;
    logic [TAG_WIDTH-1:0]        r_rd_data;
    logic [TAG_WIDTH-1:0]        r_pd_data;
    logic                        r_dup;
    logic                        r_found;

    logic                        r_out_valid;
    logic                        r_kind;
    logic [bta_pkg::ID_W-1:0]    r_out_id;
    logic [bta_pkg::STATUS_W-1:0] r_status;
    logic                        r_last;

    logic [LW-1:0]               w_lim;
    logic [RA-1:0]               w_free;
    logic                        w_out_free;
    logic                        w_place;
    logic [TAG_WIDTH-1:0]        w_place_tag;
    logic                        w_load;
    logic [RA-1:0]               w_ridx;
    logic                        w_run_hit;
    logic                        w_pend_hit;
    logic [PA-1:0]               w_rd_addr;
    logic [PA-1:0]               w_wr_addr;
    logic                        w_pend_wr;
    logic [TAG_WIDTH-1:0]        w_pend_wdata;

    // ring address: head plus an offset that stays within the fifo depth
    function automatic logic [PA-1:0] ring(input logic [PA-1:0] head,
                                           input logic [PC-1:0] off);
        logic [PC:0] sum;
        sum = (PC+1)'(head) + (PC+1)'(off);
        if (sum >= (PC+1)'(PEND_DEPTH))
            sum = sum - (PC+1)'(PEND_DEPTH);
        return sum[PA-1:0];
    endfunction

    assign w_lim = (LW'(r_limit) > LW'(RUN_SLOTS)) ? LW'(RUN_SLOTS) : LW'(r_limit);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_ridx     = r_idx[RA-1:0];
    assign w_run_hit  = r_run_vld[w_ridx] && (r_rd_data == r_tag);
    assign w_pend_hit = (r_pd_data == r_tag);

    // lowest free running slot
    always_comb begin
        w_free = '0;
        for (int i = RUN_SLOTS - 1; i >= 0; i--) begin
            if (!r_run_vld[i])
                w_free = RA'(i);
        end
    end

    assign w_place     = i_cmd.promote_take || i_cmd.add_start;
    assign w_place_tag = i_cmd.promote_take ? r_pd_data : r_tag;
    assign w_load      = w_place || i_cmd.emit_status;

    assign w_rd_addr = i_cmd.pend_rd_head ? r_head : ring(r_head, r_idx[PC-1:0]);
    assign w_wr_addr = i_cmd.add_queue ? ring(r_head, r_count) : ring(r_head, r_wptr);
    assign w_pend_wr = i_cmd.add_queue || (i_cmd.pend_cmp && r_req_type && !w_pend_hit);
    assign w_pend_wdata = i_cmd.add_queue ? r_tag : r_pd_data;

    always_ff @(posedge i_clk) begin
        if (w_place)
            run_mem[w_free] <= w_place_tag;
        if (i_cmd.run_rd)
            r_rd_data <= run_mem[w_ridx];
    end

    always_ff @(posedge i_clk) begin
        if (w_pend_wr)
            pend_mem[w_wr_addr] <= w_pend_wdata;
        if (i_cmd.pend_rd_head || i_cmd.pend_rd_idx)
            r_pd_data <= pend_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type <= i_req_type;
            r_tag      <= TAG_WIDTH'(i_task_id);
        end
        if (w_load) begin
            r_kind   <= i_cmd.emit_status ? bta_pkg::KIND_STATUS : bta_pkg::KIND_START;
            r_out_id <= i_cmd.emit_status ? bta_pkg::ID_W'(r_tag)
                                          : bta_pkg::ID_W'(w_place_tag);
            r_status <= i_cmd.emit_status ? i_cmd.code : bta_pkg::ST_STARTED;
            r_last   <= i_cmd.emit_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= bta_pkg::LIMIT_RESET;
            r_run_vld   <= '0;
            r_run_cnt   <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_wptr      <= '0;
            r_dup       <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid)
                r_limit <= i_cfg_data;

            if (i_cmd.accept || i_cmd.idx_clr) begin
                r_idx  <= '0;
                r_wptr <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end

            if (i_cmd.accept) begin
                r_dup   <= 1'b0;
                r_found <= 1'b0;
            end

            if (i_cmd.run_cmp && w_run_hit) begin
                if (r_req_type == bta_pkg::REQ_REMOVE) begin
                    r_run_vld[w_ridx] <= 1'b0;
                    r_run_cnt         <= r_run_cnt - 1'b1;
                    r_found           <= 1'b1;
                end else begin
                    r_dup <= 1'b1;
                end
            end

            if (i_cmd.pend_cmp) begin
                if (w_pend_hit) begin
                    if (r_req_type == bta_pkg::REQ_REMOVE)
                        r_found <= 1'b1;
                    else
                        r_dup <= 1'b1;
                end else if (r_req_type == bta_pkg::REQ_REMOVE) begin
                    r_wptr <= r_wptr + 1'b1;
                end
            end

            if (i_cmd.pend_rm_done)
                r_count <= r_wptr;

            if (w_place) begin
                r_run_vld[w_free] <= 1'b1;
                r_run_cnt         <= r_run_cnt + 1'b1;
            end

            if (i_cmd.promote_take) begin
                r_head  <= (r_head == PA'(PEND_DEPTH - 1)) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end

            if (i_cmd.add_queue)
                r_count <= r_count + 1'b1;

            if (w_load)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.req_type       = r_req_type;
        o_sts.room           = LW'(r_run_cnt) < w_lim;
        o_sts.pend_nonempty  = (r_count != '0);
        o_sts.pend_full      = (r_count == PC'(PEND_DEPTH));
        o_sts.run_last       = (r_idx == IW'(RUN_SLOTS - 1));
        o_sts.pend_scan_done = (r_idx >= IW'(r_count));
        o_sts.dup            = r_dup;
        o_sts.found          = r_found;
        o_sts.out_free       = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_id    = r_out_id;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

>>> rtl/core/bounded_task_admission_unit.sv
// sequencing: one request at a time; a request runs the promotion loop and the
//   scans of every running slot and every fifo entry (an add promotes first, a
//   remove scans first), then emits; the sequencer passes through idle before the
//   next request, set by the sequential slot and fifo scans through the single
//   read port of each tag store
// reset: synchronous active low; clears slot valid bits, fifo count, limit to 10
// ----------------------------------------------------------------------------
// bounded_task_admission_unit
// admits task tags under a concurrency limit, overflow waits in a fifo
// ----------------------------------------------------------------------------
module bounded_task_admission_unit #(
    parameter int RUN_SLOTS  = bta_pkg::RUN_SLOTS_DEF,
    parameter int PEND_DEPTH = bta_pkg::PEND_DEPTH_DEF,
    parameter int TAG_WIDTH  = bta_pkg::TAG_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request word
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [bta_pkg::ID_W-1:0]      i_task_id,
    // limit register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bta_pkg::LIMIT_W-1:0]   i_cfg_data,
    // result word
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_kind,
    output logic [bta_pkg::ID_W-1:0]      o_out_id,
    output logic [bta_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last
);

    bta_pkg::t_cmd w_cmd;
    bta_pkg::t_sts w_sts;
    logic          w_busy;

    // a request is taken only while the sequencer is idle; the result word
    // sits in its own register so the next request can enter meanwhile
    assign o_in_stall  = w_busy;
    // limit writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: promotion loop, slot scan, fifo scan, decision, emit
    bta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_sts      (w_sts),
        .o_busy     (w_busy),
        .o_cmd      (w_cmd)
    );

    // tag stores, valid bits, fifo ring pointers, output register
    bta_dp #(
        .RUN_SLOTS  (RUN_SLOTS),
        .PEND_DEPTH (PEND_DEPTH),
        .TAG_WIDTH  (TAG_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_type  (i_req_type),
        .i_task_id   (i_task_id),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_out_id    (o_out_id),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

>>> sim/bounded_task_admission_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_task_admission_unit_tb
// drives add and remove requests at random pacing, predicts the start events
// and status words of each request and checks every result word in order
// ----------------------------------------------------------------------------
module bounded_task_admission_unit_tb;

    localparam int SLOTS     = bta_pkg::RUN_SLOTS_DEF;
    localparam int DEPTH     = bta_pkg::PEND_DEPTH_DEF;
    localparam int MAX_CYC   = 400000;
    // a request scans every slot and every fifo entry, then emits up to 17 words
    localparam int SETTLE    = 200;
    localparam int N_RANDOM  = 130;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // request side
    logic                         in_valid = 1'b0;
    logic                         in_type = bta_pkg::REQ_ADD;
    logic [bta_pkg::ID_W-1:0]     in_id = '0;
    logic                         o_in_stall;

    // limit register write side
    logic                         cfg_valid = 1'b0;
    logic [bta_pkg::LIMIT_W-1:0]  cfg_data = '0;
    logic                         o_cfg_ready;

    // result side
    logic                         out_stall = 1'b1;
    logic                         o_out_valid;
    logic                         o_kind;
    logic [bta_pkg::ID_W-1:0]     o_out_id;
    logic [bta_pkg::STATUS_W-1:0] o_status;
    logic                         o_last;

    typedef struct packed {
        logic                     kind;
        logic [bta_pkg::ID_W-1:0] id;
        bta_pkg::t_rstat          code;
        logic                     last;
    } t_word;

    // shadow copy of the admission state
    logic [bta_pkg::ID_W-1:0]     run_tag [SLOTS];
    logic [SLOTS-1:0]             run_busy;
    logic [bta_pkg::ID_W-1:0]     wait_tag [DEPTH];
    int                           wait_cnt;
    logic [bta_pkg::LIMIT_W-1:0]  limit_reg;

    t_word               pending_words[$];

    int  cycles = 0;
    int  errors = 0;
    int  words_seen = 0;
    int  reqs_sent = 0;
    int  hold_len = 0;     // long receiver hold-off, picked up by the receiver
    bit  no_gaps = 1'b0;   // both sides run at full rate while set
    logic [bta_pkg::ID_W-1:0] tag_pool [24];

    bounded_task_admission_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (in_type),
        .i_task_id   (in_id),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_kind      (o_kind),
        .o_out_id    (o_out_id),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, pending_words.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // admission predictor
    // ------------------------------------------------------------------------
    function automatic int busy_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) n += run_busy[i];
        return n;
    endfunction

    function automatic int eff_limit();
        return (limit_reg > SLOTS) ? SLOTS : int'(limit_reg);
    endfunction

    function automatic void push_word(logic kind, logic [bta_pkg::ID_W-1:0] id,
                                      bta_pkg::t_rstat code);
        t_word w;
        w.kind = kind;
        w.id   = id;
        w.code = code;
        w.last = (kind == bta_pkg::KIND_STATUS);
        pending_words.push_back(w);
    endfunction

    // lowest free slot takes the tag
    function automatic void take_slot(logic [bta_pkg::ID_W-1:0] tag);
        for (int i = 0; i < SLOTS; i++) begin
            if (!run_busy[i]) begin
                run_tag[i]  = tag;
                run_busy[i] = 1'b1;
                return;
            end
        end
    endfunction

    function automatic void drop_waiting(int idx);
        for (int j = idx; j + 1 < wait_cnt; j++) wait_tag[j] = wait_tag[j + 1];
        wait_cnt--;
    endfunction

    // waiting tags start in fifo order while there is room
    function automatic void promote_waiting();
        logic [bta_pkg::ID_W-1:0] tag;
        while (wait_cnt > 0 && busy_count() < eff_limit()) begin
            tag = wait_tag[0];
            drop_waiting(0);
            take_slot(tag);
            push_word(bta_pkg::KIND_START, tag, bta_pkg::ST_STARTED);
        end
    endfunction

    function automatic void admit_request(logic rtype, logic [bta_pkg::ID_W-1:0] tag);
        bit hit;
        int j;
        hit = 1'b0;
        if (rtype == bta_pkg::REQ_ADD) begin
            promote_waiting();
            for (int i = 0; i < SLOTS; i++)
                if (run_busy[i] && run_tag[i] == tag) hit = 1'b1;
            for (int k = 0; k < wait_cnt; k++)
                if (wait_tag[k] == tag) hit = 1'b1;
            if (hit) begin
                push_word(bta_pkg::KIND_STATUS, tag, bta_pkg::ST_DUPLICATE);
            end else if (busy_count() < eff_limit()) begin
                take_slot(tag);
                push_word(bta_pkg::KIND_START, tag, bta_pkg::ST_STARTED);
                push_word(bta_pkg::KIND_STATUS, tag, bta_pkg::ST_STARTED);
            end else if (wait_cnt < DEPTH) begin
                wait_tag[wait_cnt] = tag;
                wait_cnt++;
                push_word(bta_pkg::KIND_STATUS, tag, bta_pkg::ST_QUEUED);
            end else begin
                push_word(bta_pkg::KIND_STATUS, tag, bta_pkg::ST_DROPPED);
            end
        end else begin
            // take the tag out of both sets before promotion
            for (int i = 0; i < SLOTS; i++) begin
                if (run_busy[i] && run_tag[i] == tag) begin
                    run_busy[i] = 1'b0;
                    hit = 1'b1;
                end
            end
            j = 0;
            while (j < wait_cnt) begin
                if (wait_tag[j] == tag) begin
                    drop_waiting(j);
                    hit = 1'b1;
                end else begin
                    j++;
                end
            end
            promote_waiting();
            push_word(bta_pkg::KIND_STATUS, tag,
                      hit ? bta_pkg::ST_REMOVED : bta_pkg::ST_NOT_FOUND);
        end
    endfunction

    // ------------------------------------------------------------------------
    // request sender, one word per call; valid stays up into the next call
    // ------------------------------------------------------------------------
    task automatic send_req(logic rtype, logic [bta_pkg::ID_W-1:0] tag);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_type  <= rtype;
        in_id    <= tag;
        do @(posedge i_clk); while (o_in_stall);
        admit_request(rtype, tag);
        reqs_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [bta_pkg::LIMIT_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    // ------------------------------------------------------------------------
    // result receiver: random stall per word, plus the long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_len > 0) begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end
            n = no_gaps ? 0 : $urandom_range(0, 11);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word kind=%0d id=%h status=%0d last=%0d",
                             o_kind, o_out_id, o_status, o_last);
            end else begin
                want = pending_words.pop_front();
                if (o_kind !== want.kind || o_out_id !== want.id ||
                    o_status !== want.code || o_last !== want.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp kind=%0d id=%h status=%0d last=%0d,",
                                  " got kind=%0d id=%h status=%0d last=%0d"},
                                 want.kind, want.id, want.code, want.last,
                                 o_kind, o_out_id, o_status, o_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // extreme tags, duplicate, removal of running and unknown tags
    task automatic test_basic_admission();
        send_req(bta_pkg::REQ_ADD, 32'h0000_0000);
        send_req(bta_pkg::REQ_ADD, 32'hFFFF_FFFF);
        send_req(bta_pkg::REQ_ADD, 32'h0000_0000);
        send_req(bta_pkg::REQ_REMOVE, 32'h1234_5678);
        send_req(bta_pkg::REQ_REMOVE, 32'h0000_0000);
        send_req(bta_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
    endtask

    // zero limit queues everything, a raised limit promotes on the next request
    task automatic test_zero_limit();
        write_limit(5'd0);
        send_req(bta_pkg::REQ_ADD, 32'hA5A5_A5A5);
        send_req(bta_pkg::REQ_ADD, 32'h5A5A_5A5A);
        send_req(bta_pkg::REQ_ADD, 32'h0000_0001);
        send_req(bta_pkg::REQ_ADD, 32'h5A5A_5A5A);    // duplicate of a waiting tag
        send_req(bta_pkg::REQ_REMOVE, 32'h5A5A_5A5A); // removed while waiting
        write_limit(5'd31);                           // saturates at slot count
        send_req(bta_pkg::REQ_ADD, 32'h8000_0000);
        send_req(bta_pkg::REQ_REMOVE, 32'hA5A5_A5A5);
        send_req(bta_pkg::REQ_REMOVE, 32'h0000_0001);
        send_req(bta_pkg::REQ_REMOVE, 32'h8000_0000);
    endtask

    // fill the fifo, drop one, then a removal releases the longest burst
    task automatic test_fifo_full();
        write_limit(5'd1);
        for (int i = 0; i < DEPTH + 2; i++)
            send_req(bta_pkg::REQ_ADD, 32'hC000_0000 + i);
        write_limit(5'd16);
        send_req(bta_pkg::REQ_REMOVE, 32'hC000_0000);
        for (int i = 1; i <= DEPTH; i++)
            send_req(bta_pkg::REQ_REMOVE, 32'hC000_0000 + i);
    endtask

    // mostly pool tags so duplicates and removals hit, some random noise
    task automatic test_random_traffic();
        logic [bta_pkg::LIMIT_W-1:0] lims [6] = '{5'd0, 5'd1, 5'd4, 5'd10, 5'd16, 5'd31};
        logic [bta_pkg::ID_W-1:0] tag;
        for (int i = 0; i < 24; i++) tag_pool[i] = $urandom;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 50 == 0)
                write_limit((i % 100 == 0) ? lims[$urandom_range(0, 5)]
                                           : bta_pkg::LIMIT_W'($urandom_range(0, 31)));
            no_gaps = (i % 70) >= 55;
            tag = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                              : tag_pool[$urandom_range(0, 23)];
            send_req(($urandom_range(0, 9) < 6) ? bta_pkg::REQ_ADD : bta_pkg::REQ_REMOVE,
                     tag);
        end
        no_gaps = 1'b0;
    endtask

    // receiver holds off while requests keep coming, so the unit backs up
    task automatic test_backpressure();
        write_limit(5'd4);
        hold_len = 600;
        for (int i = 0; i < 30; i++)
            send_req(i[0] ? bta_pkg::REQ_REMOVE : bta_pkg::REQ_ADD,
                     32'hD000_0000 + (i >> 2));
    endtask

    initial begin
        run_busy  = '0;
        wait_cnt  = 0;
        limit_reg = bta_pkg::LIMIT_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_admission();
        test_zero_limit();
        test_fifo_full();
        test_random_traffic();
        test_backpressure();
        wait_idle();

        $display("%0d requests sent, %0d result words checked, limits 0..31 with full fifo",
                 reqs_sent, words_seen);
        $display("and a long receiver hold-off; %0d mismatches", errors);
        if (errors == 0 && pending_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
